>>> hw/rtl/sha1md_pkg.sv
// Shared types and constants for the SHA-1 message digest core.
`default_nettype none
package sha1md_pkg;
	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Front-to-back command: up to four bytes plus the end flag.
	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic        last;
	} cmd_t;

	localparam int unsigned QueueDepthDef = 4;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hefcdab89;
	localparam logic [31:0] H2 = 32'h98badcfe;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hc3d2e1f0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0]  PadByte = 8'h80;

	function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
		rol = (x << n) | (x >> (32 - n));
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/sha1md_front.sv
// Front end: clamps byte counts, drops empty items unless they end a message, queues commands.
`default_nettype none
module sha1md_front
	import sha1md_pkg::*;
#(
	parameter int unsigned QueueDepth = QueueDepthDef
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t in_item,
	input  wire logic     push,
	output logic          full,
	output cmd_t          cmd,
	output logic          cmd_valid,
	input  wire logic     cmd_take
);
	localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

	cmd_t            queue_q [QueueDepth];
	logic [AW-1:0]   rd_ptr_q, wr_ptr_q;
	logic [AW:0]     count_q;
	cmd_t            cmd_in;
	logic            keep;
	logic            wr_en, rd_en;

	always_comb begin
		cmd_in.data   = in_item.data_word;
		cmd_in.nbytes = (in_item.byte_count > 3'd4) ? 3'd4 : in_item.byte_count;
		cmd_in.last   = in_item.end_of_message;
	end

	assign full      = (count_q == (AW+1)'(QueueDepth));
	assign keep      = (cmd_in.nbytes != 3'd0) || cmd_in.last;
	assign wr_en     = push && !full && keep;
	assign rd_en     = cmd_take && cmd_valid;
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) queue_q[wr_ptr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == AW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == AW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/sha1md_back.sv
// Back end: block assembly, padding, 80-round compression and digest output.
`default_nettype none
module sha1md_back
	import sha1md_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic cmd_valid,
	output logic      cmd_take,
	output out_item_t out_item,
	output logic      empty,
	input  wire logic pop
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StByte = 3'd1;
	localparam logic [2:0] StPad  = 3'd2;
	localparam logic [2:0] StRnd  = 3'd3;
	localparam logic [2:0] StFin  = 3'd4;
	localparam logic [2:0] StOut  = 3'd5;

	logic [2:0]   state_q;
	logic [31:0]  win_q [16];
	logic [5:0]   bib_q;
	logic [31:0]  blocks_q;
	logic [31:0]  hv_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [6:0]   rnd_q;
	logic [31:0]  data_q;
	logic [2:0]   left_q;
	logic         last_q;
	logic         padding_q;  // compressing a pad block
	logic         final_q;    // pad block carries the length
	logic [63:0]  bits_q;
	logic [2:0]   oidx_q;

	logic [31:0]  f, k, m, t, x;
	logic [7:0]   pbyte;

	assign cmd_take = (state_q == StIdle);
	assign empty    = (state_q != StOut);
	assign out_item.digest_word = hv_q[oidx_q];
	assign out_item.word_index  = oidx_q;
	assign out_item.last_word   = (oidx_q == 3'd4);

	always_comb begin
		x = win_q[0] ^ win_q[2] ^ win_q[8] ^ win_q[13];
		m = (rnd_q < 7'd16) ? win_q[0] : rol(x, 1);
		priority if (rnd_q < 7'd20) begin
			f = d_q ^ (b_q & (c_q ^ d_q)); k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (d_q & (b_q | c_q)); k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q; k = K3;
		end
		t = rol(a_q, 5) + f + e_q + k + m;
		// pad byte at the current position
		if (bib_q >= 6'd56 && final_q)
			pbyte = bits_q[8'(63 - 8*(bib_q - 6'd56)) -: 8];
		else
			pbyte = 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StIdle;
			bib_q     <= '0;
			blocks_q  <= '0;
			hv_q[0] <= H0; hv_q[1] <= H1; hv_q[2] <= H2; hv_q[3] <= H3; hv_q[4] <= H4;
			rnd_q     <= '0;
			left_q    <= '0;
			last_q    <= 1'b0;
			padding_q <= 1'b0;
			final_q   <= 1'b0;
			oidx_q    <= '0;
		end else begin
			unique case (state_q)
				StIdle: if (cmd_valid) begin
					data_q <= cmd.data;
					left_q <= cmd.nbytes;
					last_q <= cmd.last;
					state_q <= StByte;
				end
				StByte: begin
					if (left_q != 3'd0) begin
						win_q[bib_q[5:2]] <= (bib_q[1:0] == 2'd0)
							? {data_q[31:24], 24'h0}
							: win_q[bib_q[5:2]] | ({24'h0, data_q[31:24]}
								<< (5'd8 * (5'd3 - {3'd0, bib_q[1:0]})));
						data_q <= data_q << 8;
						left_q <= left_q - 3'd1;
						bib_q  <= bib_q + 6'd1;
						if (bib_q == 6'd63) begin
							blocks_q  <= blocks_q + 32'd1;
							padding_q <= 1'b0;
							state_q   <= StRnd;
							rnd_q     <= '0;
							a_q <= hv_q[0]; b_q <= hv_q[1]; c_q <= hv_q[2];
							d_q <= hv_q[3]; e_q <= hv_q[4];
						end
					end else if (last_q) begin
						bits_q <= {26'd0, blocks_q, bib_q} << 3;
						win_q[bib_q[5:2]] <= (bib_q[1:0] == 2'd0)
							? {PadByte, 24'h0}
							: win_q[bib_q[5:2]] | ({24'h0, PadByte}
								<< (5'd8 * (5'd3 - {3'd0, bib_q[1:0]})));
						bib_q   <= bib_q + 6'd1;
						if (bib_q == 6'd63) begin
							padding_q <= 1'b1; final_q <= 1'b0;
							state_q   <= StRnd; rnd_q <= '0;
							a_q <= hv_q[0]; b_q <= hv_q[1]; c_q <= hv_q[2];
							d_q <= hv_q[3]; e_q <= hv_q[4];
						end else begin
							final_q <= (bib_q < 6'd56);
							state_q <= StPad;
						end
					end else
						state_q <= StIdle;
				end
				StPad: begin
					win_q[bib_q[5:2]] <= (bib_q[1:0] == 2'd0)
						? {pbyte, 24'h0}
						: win_q[bib_q[5:2]] | ({24'h0, pbyte}
							<< (5'd8 * (5'd3 - {3'd0, bib_q[1:0]})));
					bib_q <= bib_q + 6'd1;
					if (bib_q == 6'd63) begin
						padding_q <= 1'b1;
						state_q   <= StRnd; rnd_q <= '0;
						a_q <= hv_q[0]; b_q <= hv_q[1]; c_q <= hv_q[2];
						d_q <= hv_q[3]; e_q <= hv_q[4];
					end
				end
				StRnd: begin
					for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
					win_q[15] <= m;
					e_q <= d_q; d_q <= c_q; c_q <= rol(b_q, 30); b_q <= a_q; a_q <= t;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) state_q <= StFin;
				end
				StFin: begin
					hv_q[0] <= hv_q[0] + a_q; hv_q[1] <= hv_q[1] + b_q;
					hv_q[2] <= hv_q[2] + c_q; hv_q[3] <= hv_q[3] + d_q;
					hv_q[4] <= hv_q[4] + e_q;
					if (!padding_q)
						state_q <= StByte;
					else if (!final_q) begin
						final_q <= 1'b1;
						state_q <= StPad;
					end else begin
						oidx_q  <= '0;
						state_q <= StOut;
					end
				end
				StOut: if (pop) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd4) begin
						hv_q[0] <= H0; hv_q[1] <= H1; hv_q[2] <= H2;
						hv_q[3] <= H3; hv_q[4] <= H4;
						bib_q <= '0; blocks_q <= '0; final_q <= 1'b0; last_q <= 1'b0;
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/sha1_message_digest_core.sv
// SHA-1 message digest core: top level.
// Input queue: drive in_item and raise push while full is low; each such edge
// is one transfer of up to four big-endian bytes (counts above four act as four).
// Raise end_of_message on the item that closes the message (it may carry zero bytes).
// Output queue: while empty is low, out_item holds the oldest digest word;
// pop takes it. Five words h0..h4 follow each closed message, last_word on h4.
// Each command costs a dispatch step, one step per byte into the block window
// and a finishing step; every 64-byte block adds 80 rounds and a fold, all in
// the single round unit, and no new command is taken until the engine is idle.
// Closing a message costs the padding bytes at one per cycle and one or two extra
// compressions before h0 appears.
// A small command queue between the front and the compression engine lets
// the producer keep pushing while a block compresses.
// If the result side stalls, the engine holds the digest and the queue fills,
// then full rises. Reset (arst_n low) returns chain values and counters to
// their initial values and empties both queues.
`default_nettype none
module sha1_message_digest_core
	import sha1md_pkg::*;
#(
	parameter int unsigned QueueDepth = QueueDepthDef
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  in_item,
	input  wire logic      push,
	output logic           full,
	output out_item_t      out_item,
	output logic           empty,
	input  wire logic      pop
);
	cmd_t cmd;
	logic cmd_valid, cmd_take;

	sha1md_front #(.QueueDepth(QueueDepth)) u_front (
		.clk, .arst_n, .in_item, .push, .full, .cmd, .cmd_valid, .cmd_take
	);

	sha1md_back u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_take, .out_item, .empty, .pop
	);

`ifndef SYNTHESIS
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_item.word_index <= 3'd4) else $error("digest index out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item)) else $error("digest word lost");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && out_item.last_word |=> empty) else $error("extra digest word");
`endif
endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the SHA-1 message digest core.
`default_nettype none
module testbench;
	import sha1md_pkg::*;

	logic      clk;
	logic      arst_n;
	in_item_t  in_item;
	logic      push;
	logic      full;
	out_item_t out_item;
	logic      empty;
	logic      pop;

	sha1_message_digest_core uut (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .push(push), .full(full),
		.out_item(out_item), .empty(empty), .pop(pop)
	);

	// Digest predictor state.
	logic [31:0] hash_state[5];
	logic [7:0]  msg_block[64];
	int unsigned block_fill;
	logic [31:0] block_total;

	out_item_t   digest_queue[$];
	int          errors = 0;
	bit          hold_results = 0;
	bit          stim_done = 0;

	// Directed rows: data, count, end flag.
	in_item_t    directed_rows[$];
	in_item_t    stim_items[$];

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic digest_clear();
		hash_state[0] = H0; hash_state[1] = H1; hash_state[2] = H2;
		hash_state[3] = H3; hash_state[4] = H4;
		block_fill = 0;
		block_total = '0;
	endtask

	task automatic compress();
		logic [31:0] w[16];
		logic [31:0] a, b, c, d, e, f, k, t, m;
		for (int r = 0; r < 16; r++)
			w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
		d = hash_state[3]; e = hash_state[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 16) begin
				m = w[r];
			end else begin
				m = rotl(w[r & 15] ^ w[(r - 14) & 15] ^ w[(r - 8) & 15] ^ w[(r - 3) & 15], 1);
				w[r & 15] = m;
			end
			if (r < 20) begin
				f = d ^ (b & (c ^ d)); k = K0;
			end else if (r < 40) begin
				f = b ^ c ^ d; k = K1;
			end else if (r < 60) begin
				f = (b & c) | (d & (b | c)); k = K2;
			end else begin
				f = b ^ c ^ d; k = K3;
			end
			t = rotl(a, 5) + f + e + k + m;
			e = d; d = c; c = rotl(b, 30); b = a; a = t;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
		hash_state[3] += d; hash_state[4] += e;
	endtask

	// Advance the predictor by one accepted transfer.
	task automatic absorb_item(input in_item_t it);
		int unsigned n;
		logic [63:0] bit_len;
		out_item_t o;
		n = (it.byte_count > 4) ? 4 : it.byte_count;
		for (int i = 0; i < n; i++) begin
			msg_block[block_fill] = it.data_word[31 - 8*i -: 8];
			block_fill++;
			if (block_fill == 64) begin
				compress();
				block_fill = 0;
				block_total++;
			end
		end
		if (it.end_of_message) begin
			bit_len = (({32'b0, block_total} << 6) + block_fill) << 3;
			msg_block[block_fill] = PadByte;
			block_fill++;
			if (block_fill > 56) begin
				while (block_fill < 64) begin
					msg_block[block_fill] = 8'h00;
					block_fill++;
				end
				compress();
				block_fill = 0;
			end
			while (block_fill < 56) begin
				msg_block[block_fill] = 8'h00;
				block_fill++;
			end
			for (int i = 0; i < 8; i++)
				msg_block[56 + i] = bit_len[63 - 8*i -: 8];
			compress();
			for (int i = 0; i < 5; i++) begin
				o.digest_word = hash_state[i];
				o.word_index = 3'(i);
				o.last_word = (i == 4);
				digest_queue.push_back(o);
			end
			digest_clear();
		end
	endtask

	task automatic add_row(input logic [31:0] d, input logic [2:0] n, input logic e);
		in_item_t it;
		it.data_word = d; it.byte_count = n; it.end_of_message = e;
		directed_rows.push_back(it);
	endtask

	// Random message: mostly full words, sometimes partial or oversized counts.
	task automatic add_message(input int words);
		in_item_t it;
		for (int i = 0; i < words; i++) begin
			it.data_word = $urandom;
			it.byte_count = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
			it.end_of_message = (i == words - 1);
			stim_items.push_back(it);
		end
	endtask

	// Sender.
	initial begin
		int gap;
		in_item = '0;
		push = 1'b0;
		arst_n = 1'b0;
		digest_clear();
		for (int i = 0; i < 64; i++) msg_block[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Empty message, "abc", single bytes, all ones/zeros, oversized counts.
		add_row(32'h0, 3'd0, 1'b1);
		add_row(32'h61626300, 3'd3, 1'b1);
		add_row(32'hFFFFFFFF, 3'd4, 1'b0);
		add_row(32'h00000000, 3'd4, 1'b0);
		add_row(32'h5AFFFFFF, 3'd1, 1'b0);
		add_row(32'hA5000000, 3'd2, 1'b0);
		add_row(32'hDEADBEEF, 3'd0, 1'b0);
		add_row(32'h12345678, 3'd7, 1'b0);
		add_row(32'h87654321, 3'd5, 1'b0);
		add_row(32'hFFFFFFFF, 3'd6, 1'b1);
		for (int i = 0; i < 14; i++) add_row(32'hFFFFFFFF, 3'd4, i == 13);
		foreach (directed_rows[i]) stim_items.push_back(directed_rows[i]);
		// Message lengths around the 55/56/64-byte boundaries.
		for (int i = 13; i <= 17; i++) add_message(i);
		while (stim_items.size() < 360) add_message($urandom_range(1, 40));

		foreach (stim_items[i]) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			if (i > 100 && i < 160) gap = 0;
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_item <= stim_items[i];
			push <= 1'b1;
			@(posedge clk);
			while (full) @(posedge clk);
			absorb_item(stim_items[i]);
		end
		push <= 1'b0;
		stim_done = 1;
	end

	// Receiver, with one long hold-off to back the queue up.
	initial begin
		int gap;
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (digest_queue.size() == 0) begin
					$error("unexpected digest word %h", out_item.digest_word);
					errors++;
				end else begin
					out_item_t want;
					want = digest_queue.pop_front();
					if (out_item.digest_word !== want.digest_word) begin
						$error("digest_word exp %h got %h", want.digest_word,
							out_item.digest_word);
						errors++;
					end
					if (out_item.word_index !== want.word_index) begin
						$error("word_index exp %0d got %0d", want.word_index,
							out_item.word_index);
						errors++;
					end
					if (out_item.last_word !== want.last_word) begin
						$error("last_word exp %0d got %0d", want.last_word,
							out_item.last_word);
						errors++;
					end
				end
				pop <= 1'b0;
			end else if (!pop) begin
				if ($urandom_range(0, 2) != 0) begin
					gap = $urandom_range(0, 11);
					repeat (gap) @(posedge clk);
				end
				while (hold_results) @(posedge clk);
				pop <= 1'b1;
			end
		end
	end

	// Long stall: hold pop low.
	initial begin
		wait (arst_n);
		repeat (2000) @(posedge clk);
		hold_results = 1;
		force_hold();
	end

	task automatic force_hold();
		repeat (3000) @(posedge clk);
		hold_results = 0;
	endtask

	// Final check.
	initial begin
		wait (stim_done);
		while (digest_queue.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (errors == 0 && empty)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
